// ----- rtl/core/dfpp_pkg.sv -----
// ----------------------------------------------------------------------------
// dfpp_pkg
// Shared types, byte codes and helpers for the DLE framed packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dfpp_pkg;

  // Default number of payload bytes kept per frame
  localparam int unsigned PayloadKeepDefault = 2;

  // Framing and response byte codes
  localparam logic [7:0] ByteDle   = 8'h0B;
  localparam logic [7:0] ByteStart = 8'h02;
  localparam logic [7:0] ByteEnd   = 8'h03;
  localparam logic [7:0] ByteAck   = 8'h07;
  localparam logic [7:0] ByteNak   = 8'h08;

  // Response frame length and index of its last byte
  localparam int unsigned RespLen = 5;
  localparam int unsigned RespCntW = $clog2(RespLen);
  localparam logic [RespCntW-1:0] RespLast = RespCntW'(RespLen - 1);

  // Receive parser phases
  typedef enum logic [3:0] {
    PH_HUNT,
    PH_START,
    PH_TARGET,
    PH_COMMAND,
    PH_SIZE,
    PH_PAYLOAD,
    PH_CHK1,
    PH_CHK2,
    PH_TDLE,
    PH_TEND
  } phase_e;

  // Parsed frame handed from parser to responder
  typedef struct packed {
    logic       nak;
    logic [7:0] target;
    logic [7:0] command;
    logic [7:0] size;
    logic [7:0] payload_first;
    logic [7:0] payload_second;
  } resp_t;

  // Response byte at a given position of the frame
  function automatic logic [7:0] resp_byte(input logic [RespCntW-1:0] pos,
                                           input logic nak);
    logic [7:0] b;
    b = ByteDle;
    case (pos)
      RespCntW'(0): b = ByteDle;
      RespCntW'(1): b = ByteStart;
      RespCntW'(2): b = nak ? ByteNak : ByteAck;
      RespCntW'(3): b = ByteDle;
      RespCntW'(4): b = ByteEnd;
      default:      b = ByteDle;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dfpp_parser.sv -----
// ----------------------------------------------------------------------------
// dfpp_parser
// Receive side: walks the frame byte by byte, holds the header and the first
// payload bytes, and pushes one response descriptor on the END position.
// ----------------------------------------------------------------------------
`default_nettype none

module dfpp_parser #(
  parameter int unsigned PayloadKeep = dfpp_pkg::PayloadKeepDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          resp_busy_i,
  output logic               resp_push_o,
  output dfpp_pkg::resp_t    resp_o
);
  import dfpp_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic       trailer_bad_q, trailer_bad_d;
  logic [7:0] target_q, command_q, size_q;
  logic [7:0] store_q [PayloadKeep];
  logic [7:0] pay_idx;
  logic       accept;

  // Hold the END byte while the previous response still drains
  assign in_stall_o = resp_busy_i && (phase_q == PH_TEND);
  assign accept     = in_valid_i && !in_stall_o;

  assign pay_idx = size_q - bytes_left_q;

  // Next phase and counters
  always_comb begin
    phase_d       = phase_q;
    bytes_left_d  = bytes_left_q;
    trailer_bad_d = trailer_bad_q;
    case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == ByteDle) phase_d = PH_START;
      end
      PH_START: begin
        if (rx_byte_i == ByteStart) begin
          trailer_bad_d = 1'b0;
          phase_d       = PH_TARGET;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_TARGET:  phase_d = PH_COMMAND;
      PH_COMMAND: phase_d = PH_SIZE;
      PH_SIZE: begin
        bytes_left_d = rx_byte_i;
        phase_d      = (rx_byte_i == 8'd0) ? PH_CHK1 : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        bytes_left_d = bytes_left_q - 8'd1;
        if (bytes_left_q == 8'd1) phase_d = PH_CHK1;
      end
      PH_CHK1: phase_d = PH_CHK2;
      PH_CHK2: phase_d = PH_TDLE;
      PH_TDLE: begin
        trailer_bad_d = (rx_byte_i != ByteDle);
        phase_d       = PH_TEND;
      end
      PH_TEND: begin
        trailer_bad_d = 1'b0;
        phase_d       = PH_HUNT;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HUNT;
      bytes_left_q  <= 8'd0;
      trailer_bad_q <= 1'b0;
    end else if (accept) begin
      phase_q       <= phase_d;
      bytes_left_q  <= bytes_left_d;
      trailer_bad_q <= trailer_bad_d;
    end
  end

  // Header fields, always written before a response can go out
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (phase_q == PH_TARGET)  target_q  <= rx_byte_i;
      if (phase_q == PH_COMMAND) command_q <= rx_byte_i;
      if (phase_q == PH_SIZE)    size_q    <= rx_byte_i;
    end
  end

  // Kept payload bytes: cleared on START, filled in arrival order
  for (genvar k = 0; k < PayloadKeep; k++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (accept) begin
        if (phase_q == PH_START && rx_byte_i == ByteStart) begin
          store_q[k] <= 8'd0;
        end else if (phase_q == PH_PAYLOAD && pay_idx == 8'(k)) begin
          store_q[k] <= rx_byte_i;
        end
      end
    end
  end

  // Response descriptor
  assign resp_push_o          = accept && (phase_q == PH_TEND);
  assign resp_o.nak           = trailer_bad_q || (rx_byte_i != ByteEnd);
  assign resp_o.target        = target_q;
  assign resp_o.command       = command_q;
  assign resp_o.size          = size_q;
  assign resp_o.payload_first = store_q[0];

  if (PayloadKeep > 1) begin : g_second
    assign resp_o.payload_second = store_q[1];
  end else begin : g_no_second
    assign resp_o.payload_second = 8'd0;
  end

  // Checks
  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_push_o |-> !resp_busy_i)
    else $error("response pushed while responder busy");

  a_pay_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (bytes_left_q != 8'd0))
    else $error("payload phase with no bytes left");

  a_tend_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_push_o |=> (phase_q == PH_HUNT) && !trailer_bad_q)
    else $error("parser did not return to hunt after frame");

endmodule

`default_nettype wire

// ----- rtl/core/dfpp_resp.sv -----
// ----------------------------------------------------------------------------
// dfpp_resp
// Transmit side: holds one response descriptor and plays out the five-byte
// ACK or NAK frame, decoded from the registered byte counter and descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module dfpp_resp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             resp_push_i,
  input  wire dfpp_pkg::resp_t  resp_i,
  output logic                  resp_busy_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            tx_byte_o,
  output logic                  last_byte_o,
  output logic                  is_nak_o,
  output logic [7:0]            frame_target_o,
  output logic [7:0]            frame_command_o,
  output logic [7:0]            frame_size_o,
  output logic [7:0]            payload_first_o,
  output logic [7:0]            payload_second_o
);
  import dfpp_pkg::*;

  logic                busy_q, busy_d;
  logic [RespCntW-1:0] cnt_q, cnt_d;
  resp_t               desc_q;
  logic                out_accept;

  assign out_accept = busy_q && !out_stall_i;

  // Byte counter and busy flag
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (resp_push_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (out_accept) begin
      if (cnt_q == RespLast) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + RespCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Descriptor register
  always_ff @(posedge clk_i) begin
    if (resp_push_i) desc_q <= resp_i;
  end

  assign resp_busy_o      = busy_q;
  assign out_valid_o      = busy_q;
  assign tx_byte_o        = resp_byte(cnt_q, desc_q.nak);
  assign last_byte_o      = (cnt_q == RespLast);
  assign is_nak_o         = desc_q.nak;
  assign frame_target_o   = desc_q.target;
  assign frame_command_o  = desc_q.command;
  assign frame_size_o     = desc_q.size;
  assign payload_first_o  = desc_q.payload_first;
  assign payload_second_o = desc_q.payload_second;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= RespLast))
    else $error("response counter out of range");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_accept && last_byte_o && !resp_push_i |=> !busy_q)
    else $error("responder still busy after last byte");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && out_stall_i |=> busy_q && $stable(cnt_q))
    else $error("response position moved while stalled");

  a_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_push_i |=> busy_q && (cnt_q == '0))
    else $error("response did not start at first byte");

endmodule

`default_nettype wire

// ----- rtl/core/dle_framed_packet_parser.sv -----
// ----------------------------------------------------------------------------
// dle_framed_packet_parser
// Latency: the first response byte is valid the cycle after the END-position
//   byte is accepted; the five bytes follow one per cycle when not stalled.
// Throughput: one received byte per cycle; the END-position byte alone is
//   held off while the previous response is still draining.
// Reset: asynchronous, clears the parser to the DLE hunt and the responder
//   to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module dle_framed_packet_parser #(
  parameter int unsigned PayloadKeep = dfpp_pkg::PayloadKeepDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      tx_byte_o,
  output logic            last_byte_o,
  output logic            is_nak_o,
  output logic [7:0]      frame_target_o,
  output logic [7:0]      frame_command_o,
  output logic [7:0]      frame_size_o,
  output logic [7:0]      payload_first_o,
  output logic [7:0]      payload_second_o
);
  import dfpp_pkg::*;

  logic  resp_busy;
  logic  resp_push;
  resp_t resp;

  // Receive parser
  dfpp_parser #(
    .PayloadKeep (PayloadKeep)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .resp_busy_i (resp_busy),
    .resp_push_o (resp_push),
    .resp_o      (resp)
  );

  // Response generator
  dfpp_resp u_resp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .resp_push_i      (resp_push),
    .resp_i           (resp),
    .resp_busy_o      (resp_busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .tx_byte_o        (tx_byte_o),
    .last_byte_o      (last_byte_o),
    .is_nak_o         (is_nak_o),
    .frame_target_o   (frame_target_o),
    .frame_command_o  (frame_command_o),
    .frame_size_o     (frame_size_o),
    .payload_first_o  (payload_first_o),
    .payload_second_o (payload_second_o)
  );

endmodule

`default_nettype wire
